FILE: rtl/core/tte_pkg.sv
package tte_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned TimeW = 48;
  localparam int unsigned IdW = 32;
  localparam int unsigned TagW = 32;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_STEP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ARM    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_EXPIRE = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_ARM_WR,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] expiry;
    logic [IdW-1:0]   id;
    logic [TagW-1:0]  tag;
  } entry_t;

endpackage

FILE: rtl/core/tte_ram.sv
module tte_ram
  import tte_pkg::*;
(
  input  logic            clk,
  input  logic            we,
  input  logic [IdxW-1:0] waddr,
  input  entry_t          wdata,
  input  logic [IdxW-1:0] raddr,
  output entry_t          rdata
);

  entry_t mem [TableDepth];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/timer_table_expiry.sv
// Cancel: one memory read per table entry, a registered read, then the result
// (states ST_SCAN, ST_SCAN_LAST, ST_EMIT); arm adds an ST_ARM_WR write state.
// Step: results are the expiries, then the end marker; each expiry is one table
// sweep. An unused op code is taken and dropped with no result.
// One item at a time; the next transfer is taken only once the block is idle and
// the last result has been taken. Reset clears state, output valid, valid bits and id counter.
module timer_table_expiry
  import tte_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  input  logic [TimeW-1:0] time_ms,
  input  logic [TagW-1:0]  user_tag,
  input  logic [IdW-1:0]   cancel_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic             ok,
  output logic [IdW-1:0]   timer_id,
  output logic [TagW-1:0]  expired_tag,
  output logic             last
);

  state_t state, state_next;

  logic [TableDepth-1:0] valid_bits;
  logic [IdW-1:0]        next_id;

  // Held item
  op_t              cur_op;
  logic [TimeW-1:0] cur_time;
  logic [TagW-1:0]  cur_tag;
  logic [IdW-1:0]   cur_cid;

  // Sweep state
  logic [IdxW-1:0]  scan_idx;   // address being read
  logic [IdxW-1:0]  data_idx;   // address of rdata
  logic             data_live;
  logic             best_hit;
  logic [IdxW-1:0]  best_idx;
  entry_t           best;
  logic             free_hit;
  logic [IdxW-1:0]  free_idx;

  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  entry_t           ram_wdata;
  entry_t           rdata;

  tte_ram u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx),
    .rdata(rdata)
  );

  logic accept_in, accept_out;
  assign accept_in  = in_valid && !in_stall;
  assign accept_out = out_valid && !out_stall;
  assign in_stall   = (state != ST_IDLE) || out_valid;

  // Compare the entry read this cycle against the running best
  logic cand_due, cand_better, cand_match;
  always_comb begin
    cand_due    = data_live && valid_bits[data_idx] && (rdata.expiry < cur_time);
    cand_better = cand_due && (!best_hit || (rdata.expiry < best.expiry) ||
                  ((rdata.expiry == best.expiry) && (rdata.id < best.id)));
    cand_match  = data_live && valid_bits[data_idx] && (rdata.id == cur_cid);
  end

  logic scan_end;
  assign scan_end = (scan_idx == IdxW'(TableDepth - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (accept_in && (op_t'(op) != OP_NONE)) state_next = ST_SCAN;
      ST_SCAN:      if (scan_end) state_next = ST_SCAN_LAST;
      ST_SCAN_LAST: state_next = (cur_op == OP_ARM) ? ST_ARM_WR : ST_EMIT;
      ST_ARM_WR:    state_next = ST_EMIT;
      ST_EMIT:      if (!out_valid || accept_out) state_next = ST_DONE;
      ST_DONE:      if (!out_valid || accept_out) begin
        state_next = (cur_op == OP_STEP && best_hit) ? ST_SCAN : ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Arm writes the held item into the free slot
  always_comb begin
    ram_we           = (state == ST_ARM_WR) && free_hit;
    ram_waddr        = free_idx;
    ram_wdata.expiry = cur_time;
    ram_wdata.id     = next_id;
    ram_wdata.tag    = cur_tag;
  end

  // Capture item, sweep, and track the best candidate
  always_ff @(posedge clk) begin
    if (accept_in) begin
      cur_op   <= op_t'(op);
      cur_time <= time_ms;
      cur_tag  <= user_tag;
      cur_cid  <= cancel_id;
    end
    data_idx  <= scan_idx;
    data_live <= (state == ST_SCAN);
    if ((state == ST_IDLE) || ((state == ST_DONE) && (state_next != ST_DONE))) begin
      scan_idx <= '0;
      best_hit <= 1'b0;
      free_hit <= 1'b0;
    end else if (state == ST_SCAN || state == ST_SCAN_LAST) begin
      if (state == ST_SCAN) scan_idx <= scan_idx + IdxW'(1);
      if (cur_op == OP_STEP) begin
        if (cand_better) begin
          best_hit <= 1'b1;
          best_idx <= data_idx;
          best     <= rdata;
        end
      end else if (cur_op == OP_CANCEL) begin
        if (cand_match && !best_hit) begin
          best_hit <= 1'b1;
          best_idx <= data_idx;
        end
      end
      // Free slot search uses the valid bits directly, lowest index wins
      if (state == ST_SCAN && !valid_bits[scan_idx] && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= scan_idx;
      end
    end
  end

  // Valid bits and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      next_id    <= '0;
    end else if (state == ST_ARM_WR) begin
      if (free_hit) begin
        valid_bits[free_idx] <= 1'b1;
        next_id              <= next_id + IdW'(1);
      end
    end else if (state == ST_EMIT && (!out_valid || accept_out)) begin
      if (cur_op != OP_ARM && best_hit) valid_bits[best_idx] <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && (!out_valid || accept_out)) begin
      out_valid   <= 1'b1;
      unique case (cur_op)
        OP_ARM: begin
          kind        <= KIND_ARM;
          ok          <= free_hit;
          timer_id    <= free_hit ? next_id - IdW'(1) : '0;
          expired_tag <= '0;
          last        <= 1'b1;
        end
        OP_CANCEL: begin
          kind        <= KIND_CANCEL;
          ok          <= best_hit;
          timer_id    <= '0;
          expired_tag <= '0;
          last        <= 1'b1;
        end
        default: begin
          kind        <= best_hit ? KIND_EXPIRE : KIND_END;
          ok          <= 1'b1;
          timer_id    <= best_hit ? best.id : '0;
          expired_tag <= best_hit ? best.tag : '0;
          last        <= !best_hit;
        end
      endcase
    end else if (accept_out) begin
      out_valid <= 1'b0;
    end
  end

  // A new item is never taken while a result waits
  assert property (@(posedge clk) disable iff (rst) accept_in |-> !out_valid)
    else $error("item accepted with result pending");

  // Sweep runs only while busy
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> in_stall)
    else $error("input open during sweep");

  // Arm write targets a free slot
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !valid_bits[ram_waddr])
    else $error("arm overwrote a live timer");

  // Expired results carry ok set and last clear
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_EXPIRE) |-> (ok && !last))
    else $error("bad expiry result");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tte_pkg::*;

  typedef struct {
    kind_t            kind;
    logic             ok;
    logic [IdW-1:0]   id;
    logic [TagW-1:0]  tag;
    logic             last;
  } timer_event_t;

  // Shadow timer table: predicts the result stream and checks it in order
  class timer_book;
    bit               slot_used [TableDepth];
    logic [TimeW-1:0] slot_expiry [TableDepth];
    logic [IdW-1:0]   slot_id [TableDepth];
    logic [TagW-1:0]  slot_tag [TableDepth];
    logic [IdW-1:0]   id_counter;
    timer_event_t     pending [$];
    int               mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 0;
      id_counter = '0;
      mismatches = 0;
    endfunction

    function void push(kind_t k, logic o, logic [IdW-1:0] i, logic [TagW-1:0] t, logic l);
      timer_event_t e;
      e.kind = k; e.ok = o; e.id = i; e.tag = t; e.last = l;
      pending.insert(pending.size(), e);
    endfunction

    // Predict the results of one accepted input transfer
    function void note_item(op_t code, logic [TimeW-1:0] t, logic [TagW-1:0] utag,
                            logic [IdW-1:0] cid);
      int best;
      int hit;
      int n;
      case (code)
        OP_ARM: begin
          hit = -1;
          for (int i = 0; i < TableDepth; i++)
            if (hit < 0 && !slot_used[i]) hit = i;
          if (hit < 0) begin
            push(KIND_ARM, 1'b0, '0, '0, 1'b1);
          end else begin
            slot_used[hit] = 1;
            slot_expiry[hit] = t;
            slot_id[hit] = id_counter;
            slot_tag[hit] = utag;
            push(KIND_ARM, 1'b1, id_counter, '0, 1'b1);
            id_counter = id_counter + 1;
          end
        end
        OP_CANCEL: begin
          hit = -1;
          for (int i = 0; i < TableDepth; i++)
            if (hit < 0 && slot_used[i] && slot_id[i] == cid) hit = i;
          if (hit >= 0) slot_used[hit] = 0;
          push(KIND_CANCEL, hit >= 0, '0, '0, 1'b1);
        end
        OP_STEP: begin
          n = 0;
          do begin
            best = -1;
            for (int i = 0; i < TableDepth; i++) begin
              if (!slot_used[i] || slot_expiry[i] >= t) continue;
              if (best < 0 || slot_expiry[i] < slot_expiry[best] ||
                  (slot_expiry[i] == slot_expiry[best] && slot_id[i] < slot_id[best]))
                best = i;
            end
            if (best >= 0) begin
              push(KIND_EXPIRE, 1'b1, slot_id[best], slot_tag[best], 1'b0);
              slot_used[best] = 0;
              n++;
            end
          end while (best >= 0 && n < TableDepth);
          push(KIND_END, 1'b1, '0, '0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_result(logic [1:0] k, logic o, logic [IdW-1:0] i,
                               logic [TagW-1:0] t, logic l);
      timer_event_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d ok=%0d id=%h tag=%h last=%0d",
                   k, o, i, t, l);
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind || o !== e.ok || i !== e.id || t !== e.tag || l !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp kind=%0d ok=%0d id=%h tag=%h last=%0d, ",
                    "got kind=%0d ok=%0d id=%h tag=%h last=%0d"},
                   e.kind, e.ok, e.id, e.tag, e.last, k, o, i, t, l);
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             in_valid = 0;
  logic             in_stall;
  logic [1:0]       op = OP_NONE;
  logic [TimeW-1:0] time_ms = '0;
  logic [TagW-1:0]  user_tag = '0;
  logic [IdW-1:0]   cancel_id = '0;
  logic             out_valid;
  logic             out_stall = 0;
  logic [1:0]       kind;
  logic             ok;
  logic [IdW-1:0]   timer_id;
  logic [TagW-1:0]  expired_tag;
  logic             last;

  timer_book book = new();
  logic [IdW-1:0]   issued_ids [$];
  logic [TimeW-1:0] wall = 1000;
  int               idle_cycles = 0;
  int               stall_mode = 0;

  timer_table_expiry dut (.*);

  always #6 clk = ~clk;

  // Drive one item and hold it until the transfer happens
  task automatic send(op_t code, logic [TimeW-1:0] t, logic [TagW-1:0] utag,
                      logic [IdW-1:0] cid);
    in_valid <= 1'b1;
    op <= code;
    time_ms <= t;
    user_tag <= utag;
    cancel_id <= cid;
    do @(posedge clk); while (in_stall);
    if (code == OP_ARM) issued_ids.insert(issued_ids.size(), book.id_counter);
    book.note_item(code, t, utag, cid);
  endtask

  task automatic pause(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Check output transfers and vary the stall pattern
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        book.check_result(kind, ok, timer_id, expired_tag, last);
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 40000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int burst;
    int r;
    int mode;
    logic [TimeW-1:0] t;
    logic [IdW-1:0] cid;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, ties, absent cancel, empty step, unused op
    send(OP_STEP, '0, '0, '0);
    send(OP_ARM, '0, '0, '0);
    send(OP_ARM, '1, '1, '1);
    send(OP_ARM, 48'd5, 32'h1234_5678, '0);
    send(OP_ARM, 48'd5, 32'h8765_4321, '0);
    send(OP_ARM, 48'd5, 32'hA5A5_5A5A, '0);
    send(OP_CANCEL, '0, '0, 32'd3);
    send(OP_CANCEL, '0, '0, 32'd3);
    send(OP_CANCEL, '0, '0, '1);
    send(OP_NONE, '1, '1, '1);
    send(OP_STEP, 48'd5, '0, '0);
    send(OP_STEP, 48'd6, '0, '0);
    send(OP_STEP, '1, '0, '0);
    send(OP_CANCEL, '0, '0, 32'd1);
    pause(3);

    // Random: phases that fill, churn or drain the table
    for (int n = 0; n < 310;) begin
      mode = $urandom_range(0, 3);
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < 310; b++) begin
        r = $urandom_range(0, 99);
        wall = wall + $urandom_range(0, 40);
        if (r < 2) begin
          send(OP_NONE, {$urandom, $urandom}, $urandom, $urandom);
          continue;
        end
        n++;
        if ((mode == 0 && r < 80) || (mode != 0 && r < 45)) begin
          case ($urandom_range(0, 9))
            0: t = {$urandom, $urandom};
            1: t = '1;
            2: t = wall;
            default: t = wall + $urandom_range(0, 300);
          endcase
          send(OP_ARM, t, $urandom, $urandom);
        end else if ((mode == 2 && r < 85) || r < 70) begin
          if (issued_ids.size() > 0 && $urandom_range(0, 3) != 0)
            cid = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
          else
            cid = $urandom;
          send(OP_CANCEL, {$urandom, $urandom}, $urandom, cid);
        end else begin
          case ($urandom_range(0, 9))
            0: t = {$urandom, $urandom};
            1: t = (mode == 3) ? '1 : '0;
            default: t = wall;
          endcase
          send(OP_STEP, t, $urandom, $urandom);
        end
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 20));
    end
    in_valid <= 1'b0;

    // Drain remaining results, then let the block settle
    while (book.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tte_pkg.sv
rtl/core/tte_ram.sv
rtl/core/timer_table_expiry.sv
tb/sv/tb.sv
